>>> src/pms_pkg.sv
// Package for the playback mode sequencer: mode, command and code types,
// status flag bit positions and the mode-to-code lookup.
// No dependencies.
package pms_pkg;

   typedef enum logic [3:0] {
      MODE_IDLE     = 4'd0,
      MODE_OPENING  = 4'd1,
      MODE_PREFILL  = 4'd2,
      MODE_PRIMING  = 4'd3,
      MODE_PLAYING  = 4'd4,
      MODE_PAUSED   = 4'd5,
      MODE_SEEKING  = 4'd6,
      MODE_DRAINING = 4'd7,
      MODE_ENDED    = 4'd8,
      MODE_ERROR    = 4'd9,
      MODE_CLOSING  = 4'd10
   } mode_type;

   localparam int unsigned NUM_MODES = 11;

   typedef enum logic [2:0] {
      CMD_OBSERVE        = 3'd0,
      CMD_OPEN           = 3'd1,
      CMD_SEEK           = 3'd2,
      CMD_FINISH_PRIMING = 3'd3,
      CMD_CLOSE          = 3'd4,
      CMD_FINISH_CLOSE   = 3'd5,
      CMD_FORCE          = 3'd6,
      CMD_RESET_IDLE     = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      SES_STOPPED  = 3'd0,
      SES_OPENING  = 3'd1,
      SES_STARTED  = 3'd2,
      SES_STOPPING = 3'd3,
      SES_ENDED    = 3'd4,
      SES_ERROR    = 3'd5
   } session_type;

   typedef enum logic [1:0] {
      TR_STOPPED = 2'd0,
      TR_PLAYING = 2'd1,
      TR_PAUSED  = 2'd2,
      TR_SEEKING = 2'd3
   } transport_type;

   typedef enum logic [2:0] {
      BUF_EMPTY    = 3'd0,
      BUF_PREFILL  = 3'd1,
      BUF_PRIMING  = 3'd2,
      BUF_READY    = 3'd3,
      BUF_DRAINING = 3'd4
   } buffering_type;

   typedef enum logic [1:0] {
      SEQ_IDLE = 2'd0,
      SEQ_RUN  = 2'd1,
      SEQ_DONE = 2'd2
   } seq_type;

   // status flag bit positions
   localparam int unsigned F_INIT_DONE       = 0;
   localparam int unsigned F_INIT_OK         = 1;
   localparam int unsigned F_AUDIO_PAUSED    = 2;
   localparam int unsigned F_SEEK_FAILED     = 3;
   localparam int unsigned F_DECODE_ENDED    = 4;
   localparam int unsigned F_VQ_EMPTY        = 5;
   localparam int unsigned F_SYNC_READY      = 6;
   localparam int unsigned F_AUDIO_STARTED   = 7;
   localparam int unsigned F_AUDIO_DEC_ENDED = 8;
   localparam int unsigned F_AUDIO_FINISHED  = 9;
   localparam int unsigned F_DEMUX_ENDED     = 10;
   localparam int unsigned FLAG_BITS         = 11;

   localparam int unsigned SERIAL_PORT_BITS  = 32;
   localparam int unsigned DEFAULT_PREFILL   = 8;
   localparam int unsigned DEFAULT_RATE      = 48000;

   typedef struct packed {
      session_type   session;
      transport_type transport;
      buffering_type buffering;
   } mode_info_type;

   // Snapshot reduced to flags; compares are done when the transaction is taken.
   typedef struct packed {
      logic [FLAG_BITS-1:0] flags;
      logic                 seek_idle;
      logic                 pend_eq_cur;
      logic                 shown_eq_cur;
      logic                 video_deep;
      logic                 audio_deep;
   } obs_type;

   function automatic mode_info_type mode_info(input mode_type m);
      mode_info_type r;
      unique case (m)
         MODE_IDLE:     r = '{SES_STOPPED,  TR_STOPPED, BUF_EMPTY};
         MODE_OPENING:  r = '{SES_OPENING,  TR_STOPPED, BUF_EMPTY};
         MODE_PREFILL:  r = '{SES_STARTED,  TR_PLAYING, BUF_PREFILL};
         MODE_PRIMING:  r = '{SES_STARTED,  TR_PLAYING, BUF_PRIMING};
         MODE_PLAYING:  r = '{SES_STARTED,  TR_PLAYING, BUF_READY};
         MODE_PAUSED:   r = '{SES_STARTED,  TR_PAUSED,  BUF_READY};
         MODE_SEEKING:  r = '{SES_STARTED,  TR_SEEKING, BUF_PREFILL};
         MODE_DRAINING: r = '{SES_STARTED,  TR_PLAYING, BUF_DRAINING};
         MODE_ENDED:    r = '{SES_ENDED,    TR_STOPPED, BUF_EMPTY};
         MODE_ERROR:    r = '{SES_ERROR,    TR_STOPPED, BUF_EMPTY};
         MODE_CLOSING:  r = '{SES_STOPPING, TR_STOPPED, BUF_EMPTY};
         default:       r = '{SES_STOPPED,  TR_STOPPED, BUF_EMPTY};
      endcase
      return r;
   endfunction

endpackage

>>> src/playback_mode_sequencer.sv
// Top level of the playback mode sequencer: transaction sequencer, mode register,
// command decode and registered result. Depends on pms_pkg and pms_rule_unit.
//
//   channel | ports  | direction | handshake
//   --------+--------+-----------+-------------------------------
//   request | req_*  | in        | req_valid / req_ready
//   result  | rsp_*  | out       | rsp_valid / rsp_ready
//   config  | csr_*  | in        | csr_write_enable, no wait
//
// A transaction is taken only while the sequencer is idle. A command is decoded
// in the run state; an observe runs rule steps through the shared rule unit
// there, 1 to MAX_RESOLVE_STEPS of them, until the mode settles. The done state
// then loads the result register; a result stalled by rsp_ready holds the
// sequencer in its done state. Reset (synchronous) sets the mode to idle and
// video_prefill_frames to 8.
module playback_mode_sequencer #(
   parameter int SERIAL_BITS       = 32,
   parameter int MAX_RESOLVE_STEPS = 8
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [3:0]  req_target_state,
   input  logic [10:0] req_status_flags,
   input  logic [31:0] req_seek_in_flight_serial,
   input  logic [31:0] req_pending_seek_serial,
   input  logic [31:0] req_current_serial,
   input  logic [31:0] req_last_presented_serial,
   input  logic [15:0] req_video_queue_depth,
   input  logic [23:0] req_audio_buffered_frames,
   input  logic [19:0] req_audio_sample_rate,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_previous_state,
   output logic [3:0]  rsp_current_state,
   output logic        rsp_state_changed,
   output logic        rsp_clear_seek_failure,
   output logic [2:0]  rsp_session_code,
   output logic [1:0]  rsp_transport_code,
   output logic [2:0]  rsp_buffering_code,
   output logic        rsp_hold_audio_output,
   output logic        rsp_pause_main_clock,
   output logic        rsp_may_present_video,
   output logic        rsp_ui_buffering,

   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   localparam int CMP_BITS  = (SERIAL_BITS < int'(pms_pkg::SERIAL_PORT_BITS)) ?
                              SERIAL_BITS : int'(pms_pkg::SERIAL_PORT_BITS);
   localparam int STEP_BITS = (MAX_RESOLVE_STEPS > 1) ? $clog2(MAX_RESOLVE_STEPS) : 1;

   pms_pkg::seq_type  seq_ff, seq_in;
   pms_pkg::mode_type mode_ff, mode_in;
   pms_pkg::mode_type work_ff, work_in;
   pms_pkg::mode_type rule_next;
   pms_pkg::mode_type cmd_next;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [15:0]       prefill_ff, prefill_in;

   pms_pkg::cmd_type  cmd_ff;
   logic [3:0]        target_ff;
   pms_pkg::obs_type  obs_ff, obs_now;

   logic              take, run_step, load, slot_free, settled;
   logic [19:0]       rate_eff;
   logic [26:0]       audio_x3;
   pms_pkg::mode_info_type prev_info, work_info;
   logic              buffering_like;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [3:0] prev_ff, cur_ff;
   logic       changed_ff, clear_ff;
   logic [2:0] ses_ff, buf_ff;
   logic [1:0] tr_ff;
   logic       hold_ff, pause_ff, present_ff, ui_ff;

   // snapshot reduction at accept
   assign rate_eff = (req_audio_sample_rate == '0) ?
                     20'(pms_pkg::DEFAULT_RATE) : req_audio_sample_rate;
   // frames >= rate/3  <=>  3*frames + 2 >= rate
   assign audio_x3 = {2'b00, req_audio_buffered_frames, 1'b0} +
                     {3'b000, req_audio_buffered_frames} + 27'd2;

   always_comb begin
      obs_now.flags        = req_status_flags;
      obs_now.seek_idle    = (req_seek_in_flight_serial[CMP_BITS-1:0] == '0);
      obs_now.pend_eq_cur  = (req_pending_seek_serial[CMP_BITS-1:0] ==
                              req_current_serial[CMP_BITS-1:0]);
      obs_now.shown_eq_cur = (req_last_presented_serial[CMP_BITS-1:0] ==
                              req_current_serial[CMP_BITS-1:0]);
      obs_now.video_deep   = (req_video_queue_depth >= prefill_ff);
      obs_now.audio_deep   = (audio_x3 >= {7'd0, rate_eff});
   end

   pms_rule_unit u_rule (
      .mode_i (work_ff),
      .obs_i  (obs_ff),
      .mode_o (rule_next)
   );

   assign prev_info = pms_pkg::mode_info(mode_ff);
   assign work_info = pms_pkg::mode_info(work_ff);

   always_comb begin
      cmd_next = mode_ff;
      unique case (cmd_ff)
         pms_pkg::CMD_OPEN:
            if (mode_ff == pms_pkg::MODE_IDLE) cmd_next = pms_pkg::MODE_OPENING;
         pms_pkg::CMD_SEEK:
            if (prev_info.session == pms_pkg::SES_STARTED) cmd_next = pms_pkg::MODE_SEEKING;
         pms_pkg::CMD_FINISH_PRIMING:
            if (mode_ff == pms_pkg::MODE_PRIMING) cmd_next = pms_pkg::MODE_PLAYING;
         pms_pkg::CMD_CLOSE:
            if (mode_ff != pms_pkg::MODE_IDLE) cmd_next = pms_pkg::MODE_CLOSING;
         pms_pkg::CMD_FINISH_CLOSE:
            if (mode_ff == pms_pkg::MODE_CLOSING) cmd_next = pms_pkg::MODE_IDLE;
         pms_pkg::CMD_FORCE:
            // unknown targets are ignored
            if (target_ff < 4'(pms_pkg::NUM_MODES)) cmd_next = pms_pkg::mode_type'(target_ff);
         pms_pkg::CMD_RESET_IDLE:
            cmd_next = pms_pkg::MODE_IDLE;
         default:
            cmd_next = mode_ff;
      endcase
   end

   assign settled   = (rule_next == work_ff) ||
                      (step_ff == STEP_BITS'(MAX_RESOLVE_STEPS - 1));
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // sequencer next state
   always_comb begin
      seq_in = seq_ff;
      unique case (seq_ff)
         pms_pkg::SEQ_IDLE: if (req_valid) seq_in = pms_pkg::SEQ_RUN;
         pms_pkg::SEQ_RUN:
            if (cmd_ff != pms_pkg::CMD_OBSERVE || settled) seq_in = pms_pkg::SEQ_DONE;
         pms_pkg::SEQ_DONE: if (slot_free) seq_in = pms_pkg::SEQ_IDLE;
         default: seq_in = pms_pkg::SEQ_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      run_step  = 1'b0;
      load      = 1'b0;
      unique case (seq_ff)
         pms_pkg::SEQ_IDLE: req_ready = 1'b1;
         pms_pkg::SEQ_RUN:  run_step  = 1'b1;
         pms_pkg::SEQ_DONE: load      = slot_free;
         default: ;
      endcase
   end

   assign take = req_valid && req_ready;

   always_comb begin
      work_in = work_ff;
      step_in = step_ff;
      if (take) begin
         work_in = mode_ff;
         step_in = '0;
      end else if (run_step) begin
         work_in = (cmd_ff == pms_pkg::CMD_OBSERVE) ? rule_next : cmd_next;
         step_in = step_ff + STEP_BITS'(1);
      end
   end

   assign mode_in    = load ? work_ff : mode_ff;
   assign prefill_in = csr_write_enable ? csr_write_data : prefill_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   assign buffering_like = (work_info.session == pms_pkg::SES_OPENING) ||
                           (work_info.buffering == pms_pkg::BUF_PREFILL) ||
                           (work_info.buffering == pms_pkg::BUF_PRIMING) ||
                           (work_info.transport == pms_pkg::TR_SEEKING);

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= pms_pkg::SEQ_IDLE;
         mode_ff      <= pms_pkg::MODE_IDLE;
         prefill_ff   <= 16'(pms_pkg::DEFAULT_PREFILL);
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         mode_ff      <= mode_in;
         prefill_ff   <= prefill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      step_ff <= step_in;
      if (take) begin
         cmd_ff    <= pms_pkg::cmd_type'(req_command);
         target_ff <= req_target_state;
         obs_ff    <= obs_now;
      end
      if (load) begin
         prev_ff    <= mode_ff;
         cur_ff     <= work_ff;
         changed_ff <= (mode_ff != work_ff);
         clear_ff   <= (cmd_ff == pms_pkg::CMD_OBSERVE) &&
                       (mode_ff == pms_pkg::MODE_SEEKING) &&
                       (work_ff != pms_pkg::MODE_SEEKING) && obs_ff.seek_idle;
         ses_ff     <= work_info.session;
         tr_ff      <= work_info.transport;
         buf_ff     <= work_info.buffering;
         hold_ff    <= buffering_like;
         pause_ff   <= (work_info.session != pms_pkg::SES_STARTED) ||
                       (work_info.buffering == pms_pkg::BUF_PREFILL) ||
                       (work_info.transport == pms_pkg::TR_PAUSED);
         present_ff <= (work_info.transport == pms_pkg::TR_SEEKING) ||
                       ((work_info.transport == pms_pkg::TR_PLAYING) &&
                        (work_info.buffering != pms_pkg::BUF_EMPTY) &&
                        (work_info.buffering != pms_pkg::BUF_PREFILL));
         ui_ff      <= buffering_like;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_previous_state     = prev_ff;
   assign rsp_current_state      = cur_ff;
   assign rsp_state_changed      = changed_ff;
   assign rsp_clear_seek_failure = clear_ff;
   assign rsp_session_code       = ses_ff;
   assign rsp_transport_code     = tr_ff;
   assign rsp_buffering_code     = buf_ff;
   assign rsp_hold_audio_output  = hold_ff;
   assign rsp_pause_main_clock   = pause_ff;
   assign rsp_may_present_video  = present_ff;
   assign rsp_ui_buffering       = ui_ff;

   // while a result is pending, the held mode matches it
   a_mode_matches_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (mode_ff == pms_pkg::mode_type'(cur_ff)))
      else $error("mode register differs from pending result");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (seq_ff != pms_pkg::SEQ_IDLE) |-> !req_ready)
      else $error("request taken while sequencer busy");

   a_changed_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (changed_ff == (prev_ff != cur_ff)))
      else $error("state_changed inconsistent with states");

   a_clear_from_seek: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && clear_ff) |->
         (prev_ff == 4'(pms_pkg::MODE_SEEKING) && cur_ff != 4'(pms_pkg::MODE_SEEKING)))
      else $error("clear_seek_failure without leaving seeking");

endmodule

>>> src/pms_rule_unit.sv
// One transition rule step of the playback mode for an observed snapshot.
// Depends on pms_pkg (mode_type, obs_type, flag positions, mode_info).
module pms_rule_unit (
   input  pms_pkg::mode_type mode_i,
   input  pms_pkg::obs_type  obs_i,
   output pms_pkg::mode_type mode_o
);

   logic paused, dec_end, vq_empty, a_fin, a_active, active, prefill_ok;
   pms_pkg::mode_info_type info;

   assign info     = pms_pkg::mode_info(mode_i);
   assign active   = (info.session == pms_pkg::SES_STARTED) &&
                     (info.transport == pms_pkg::TR_PLAYING);
   assign paused   = obs_i.flags[pms_pkg::F_AUDIO_PAUSED];
   assign dec_end  = obs_i.flags[pms_pkg::F_DECODE_ENDED];
   assign vq_empty = obs_i.flags[pms_pkg::F_VQ_EMPTY];
   assign a_fin    = obs_i.flags[pms_pkg::F_AUDIO_FINISHED];
   assign a_active = obs_i.flags[pms_pkg::F_AUDIO_STARTED] && !a_fin;

   assign prefill_ok = (obs_i.video_deep || dec_end) &&
                       (!obs_i.flags[pms_pkg::F_AUDIO_STARTED] ||
                        obs_i.flags[pms_pkg::F_AUDIO_DEC_ENDED] ||
                        (obs_i.audio_deep && obs_i.flags[pms_pkg::F_SYNC_READY]));

   always_comb begin
      mode_o = mode_i;
      if (mode_i == pms_pkg::MODE_OPENING && obs_i.flags[pms_pkg::F_INIT_DONE]) begin
         if (!obs_i.flags[pms_pkg::F_INIT_OK])
            mode_o = pms_pkg::MODE_ERROR;
         else
            mode_o = paused ? pms_pkg::MODE_PAUSED : pms_pkg::MODE_PREFILL;
      end else if (mode_i == pms_pkg::MODE_SEEKING && obs_i.seek_idle) begin
         // a paused, unfailed seek on the current stream stays put until video runs dry
         if (!obs_i.flags[pms_pkg::F_SEEK_FAILED] && paused && obs_i.pend_eq_cur &&
             !(dec_end && vq_empty))
            mode_o = pms_pkg::MODE_SEEKING;
         else
            mode_o = paused ? pms_pkg::MODE_PAUSED : pms_pkg::MODE_PREFILL;
      end else if (active && paused) begin
         mode_o = pms_pkg::MODE_PAUSED;
      end else if (mode_i == pms_pkg::MODE_PAUSED && !paused) begin
         mode_o = obs_i.shown_eq_cur ? pms_pkg::MODE_PLAYING : pms_pkg::MODE_PREFILL;
      end else if (mode_i == pms_pkg::MODE_PREFILL && !paused && prefill_ok) begin
         mode_o = pms_pkg::MODE_PRIMING;
      end else if (active) begin
         if (dec_end && vq_empty && (!a_active || a_fin))
            mode_o = pms_pkg::MODE_ENDED;
         else if (obs_i.flags[pms_pkg::F_DEMUX_ENDED] &&
                  mode_i == pms_pkg::MODE_PLAYING && vq_empty)
            mode_o = pms_pkg::MODE_DRAINING;
      end
   end

endmodule

>>> tb/sv/playback_mode_sequencer_test.sv
// Self-checking testbench for playback_mode_sequencer: queued stimulus, a clocked
// driver and monitor, and a transaction-level predictor of the playback mode.
// Depends on pms_pkg and the playback_mode_sequencer RTL.
`timescale 1ns / 1ps

module playback_mode_sequencer_test;

   localparam int SERIAL_W       = 32;
   localparam int MAX_STEPS      = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 250;
   localparam int PHASES         = 6;
   localparam int PHASE_ITEMS    = 65;
   localparam logic [31:0] SER_MASK = (SERIAL_W >= 32) ? 32'hFFFF_FFFF
                                                       : ((32'd1 << SERIAL_W) - 32'd1);

   localparam logic [10:0] FL_INIT_DONE     = 11'd1 << pms_pkg::F_INIT_DONE;
   localparam logic [10:0] FL_INIT_OK       = 11'd1 << pms_pkg::F_INIT_OK;
   localparam logic [10:0] FL_PAUSED        = 11'd1 << pms_pkg::F_AUDIO_PAUSED;
   localparam logic [10:0] FL_SEEK_FAILED   = 11'd1 << pms_pkg::F_SEEK_FAILED;
   localparam logic [10:0] FL_DECODE_ENDED  = 11'd1 << pms_pkg::F_DECODE_ENDED;
   localparam logic [10:0] FL_VQ_EMPTY      = 11'd1 << pms_pkg::F_VQ_EMPTY;
   localparam logic [10:0] FL_SYNC_READY    = 11'd1 << pms_pkg::F_SYNC_READY;
   localparam logic [10:0] FL_AUDIO_STARTED = 11'd1 << pms_pkg::F_AUDIO_STARTED;
   localparam logic [10:0] FL_AUDIO_FIN     = 11'd1 << pms_pkg::F_AUDIO_FINISHED;
   localparam logic [10:0] FL_DEMUX_ENDED   = 11'd1 << pms_pkg::F_DEMUX_ENDED;

   typedef struct packed {
      pms_pkg::cmd_type command;
      logic [3:0]  target;
      logic [10:0] flags;
      logic [31:0] seek_serial;
      logic [31:0] pend_serial;
      logic [31:0] cur_serial;
      logic [31:0] shown_serial;
      logic [15:0] depth;
      logic [23:0] buffered;
      logic [19:0] rate;
   } request_type;

   typedef struct packed {
      pms_pkg::mode_type      prev_mode;
      pms_pkg::mode_type      mode;
      logic                   changed;
      logic                   clear_fail;
      pms_pkg::session_type   session;
      pms_pkg::transport_type transport;
      pms_pkg::buffering_type buffering;
      logic                   hold_audio;
      logic                   pause_clock;
      logic                   present_video;
      logic                   ui_busy;
   } response_type;

   typedef struct packed {
      pms_pkg::session_type   session;
      pms_pkg::transport_type transport;
      pms_pkg::buffering_type buffering;
   } codes_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_command = '0;
   logic [3:0]  req_target_state = '0;
   logic [10:0] req_status_flags = '0;
   logic [31:0] req_seek_in_flight_serial = '0;
   logic [31:0] req_pending_seek_serial = '0;
   logic [31:0] req_current_serial = '0;
   logic [31:0] req_last_presented_serial = '0;
   logic [15:0] req_video_queue_depth = '0;
   logic [23:0] req_audio_buffered_frames = '0;
   logic [19:0] req_audio_sample_rate = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_previous_state;
   logic [3:0]  rsp_current_state;
   logic        rsp_state_changed;
   logic        rsp_clear_seek_failure;
   logic [2:0]  rsp_session_code;
   logic [1:0]  rsp_transport_code;
   logic [2:0]  rsp_buffering_code;
   logic        rsp_hold_audio_output;
   logic        rsp_pause_main_clock;
   logic        rsp_may_present_video;
   logic        rsp_ui_buffering;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;

   request_type  request_queue[$];
   response_type predicted_results[$];
   logic [15:0] prefill_cfg = 16'd8;
   pms_pkg::mode_type gen_mode = pms_pkg::MODE_IDLE;
   pms_pkg::mode_type model_mode = pms_pkg::MODE_IDLE;
   int        queued_count = 0;
   int        accepted_count = 0;
   int        checked_count = 0;
   int        errors = 0;
   int        hold_requests = 0;
   int        quiet_cycles = 0;
   logic [pms_pkg::NUM_MODES-1:0] modes_seen = '0;

   playback_mode_sequencer #(
      .SERIAL_BITS(SERIAL_W),
      .MAX_RESOLVE_STEPS(MAX_STEPS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_target_state(req_target_state),
      .req_status_flags(req_status_flags),
      .req_seek_in_flight_serial(req_seek_in_flight_serial),
      .req_pending_seek_serial(req_pending_seek_serial),
      .req_current_serial(req_current_serial),
      .req_last_presented_serial(req_last_presented_serial),
      .req_video_queue_depth(req_video_queue_depth),
      .req_audio_buffered_frames(req_audio_buffered_frames),
      .req_audio_sample_rate(req_audio_sample_rate),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_previous_state(rsp_previous_state),
      .rsp_current_state(rsp_current_state),
      .rsp_state_changed(rsp_state_changed),
      .rsp_clear_seek_failure(rsp_clear_seek_failure),
      .rsp_session_code(rsp_session_code),
      .rsp_transport_code(rsp_transport_code),
      .rsp_buffering_code(rsp_buffering_code),
      .rsp_hold_audio_output(rsp_hold_audio_output),
      .rsp_pause_main_clock(rsp_pause_main_clock),
      .rsp_may_present_video(rsp_may_present_video),
      .rsp_ui_buffering(rsp_ui_buffering),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic codes_type mode_codes(pms_pkg::mode_type m);
      codes_type c;
      case (m)
         pms_pkg::MODE_OPENING:
            c = '{pms_pkg::SES_OPENING,  pms_pkg::TR_STOPPED, pms_pkg::BUF_EMPTY};
         pms_pkg::MODE_PREFILL:
            c = '{pms_pkg::SES_STARTED,  pms_pkg::TR_PLAYING, pms_pkg::BUF_PREFILL};
         pms_pkg::MODE_PRIMING:
            c = '{pms_pkg::SES_STARTED,  pms_pkg::TR_PLAYING, pms_pkg::BUF_PRIMING};
         pms_pkg::MODE_PLAYING:
            c = '{pms_pkg::SES_STARTED,  pms_pkg::TR_PLAYING, pms_pkg::BUF_READY};
         pms_pkg::MODE_PAUSED:
            c = '{pms_pkg::SES_STARTED,  pms_pkg::TR_PAUSED,  pms_pkg::BUF_READY};
         pms_pkg::MODE_SEEKING:
            c = '{pms_pkg::SES_STARTED,  pms_pkg::TR_SEEKING, pms_pkg::BUF_PREFILL};
         pms_pkg::MODE_DRAINING:
            c = '{pms_pkg::SES_STARTED,  pms_pkg::TR_PLAYING, pms_pkg::BUF_DRAINING};
         pms_pkg::MODE_ENDED:
            c = '{pms_pkg::SES_ENDED,    pms_pkg::TR_STOPPED, pms_pkg::BUF_EMPTY};
         pms_pkg::MODE_ERROR:
            c = '{pms_pkg::SES_ERROR,    pms_pkg::TR_STOPPED, pms_pkg::BUF_EMPTY};
         pms_pkg::MODE_CLOSING:
            c = '{pms_pkg::SES_STOPPING, pms_pkg::TR_STOPPED, pms_pkg::BUF_EMPTY};
         default:
            c = '{pms_pkg::SES_STOPPED,  pms_pkg::TR_STOPPED, pms_pkg::BUF_EMPTY};
      endcase
      return c;
   endfunction

   function automatic logic is_rolling(pms_pkg::mode_type m);
      codes_type c;
      c = mode_codes(m);
      return c.session == pms_pkg::SES_STARTED && c.transport == pms_pkg::TR_PLAYING;
   endfunction

   function automatic logic buffers_ready(request_type it, logic [15:0] prefill);
      int unsigned need;
      logic video_ok, audio_ok;
      need = ((it.rate == 0) ? pms_pkg::DEFAULT_RATE : int'(it.rate)) / 3;
      video_ok = it.depth >= prefill || it.flags[pms_pkg::F_DECODE_ENDED];
      audio_ok = !it.flags[pms_pkg::F_AUDIO_STARTED] || it.flags[pms_pkg::F_AUDIO_DEC_ENDED] ||
                 (it.buffered >= need && it.flags[pms_pkg::F_SYNC_READY]);
      return video_ok && audio_ok;
   endfunction

   function automatic pms_pkg::mode_type apply_rules(pms_pkg::mode_type s, request_type it,
                                                     logic [15:0] prefill);
      logic paused, dec_end, vq_empty, a_fin, a_active;
      pms_pkg::mode_type nxt;
      paused   = it.flags[pms_pkg::F_AUDIO_PAUSED];
      dec_end  = it.flags[pms_pkg::F_DECODE_ENDED];
      vq_empty = it.flags[pms_pkg::F_VQ_EMPTY];
      a_fin    = it.flags[pms_pkg::F_AUDIO_FINISHED];
      a_active = it.flags[pms_pkg::F_AUDIO_STARTED] && !a_fin;
      nxt = s;
      if (s == pms_pkg::MODE_OPENING && it.flags[pms_pkg::F_INIT_DONE]) begin
         if (!it.flags[pms_pkg::F_INIT_OK]) nxt = pms_pkg::MODE_ERROR;
         else if (paused) nxt = pms_pkg::MODE_PAUSED;
         else nxt = pms_pkg::MODE_PREFILL;
      end else if (s == pms_pkg::MODE_SEEKING && (it.seek_serial & SER_MASK) == 0) begin
         // a paused seek onto the current stream stays put until it fails or ends
         if (!it.flags[pms_pkg::F_SEEK_FAILED] && paused &&
             (it.pend_serial & SER_MASK) == (it.cur_serial & SER_MASK) &&
             !(dec_end && vq_empty))
            nxt = pms_pkg::MODE_SEEKING;
         else if (paused) nxt = pms_pkg::MODE_PAUSED;
         else nxt = pms_pkg::MODE_PREFILL;
      end else if (is_rolling(s) && paused) begin
         nxt = pms_pkg::MODE_PAUSED;
      end else if (s == pms_pkg::MODE_PAUSED && !paused) begin
         if ((it.shown_serial & SER_MASK) == (it.cur_serial & SER_MASK))
            nxt = pms_pkg::MODE_PLAYING;
         else nxt = pms_pkg::MODE_PREFILL;
      end else if (s == pms_pkg::MODE_PREFILL && !paused && buffers_ready(it, prefill)) begin
         nxt = pms_pkg::MODE_PRIMING;
      end else if (is_rolling(s)) begin
         if (dec_end && vq_empty && (!a_active || a_fin)) nxt = pms_pkg::MODE_ENDED;
         else if (it.flags[pms_pkg::F_DEMUX_ENDED] && s == pms_pkg::MODE_PLAYING && vq_empty)
            nxt = pms_pkg::MODE_DRAINING;
      end
      return nxt;
   endfunction

   function automatic response_type predict_response(pms_pkg::mode_type prev, request_type it,
                                                     logic [15:0] prefill);
      response_type r;
      pms_pkg::mode_type nxt, stepped;
      codes_type c, prev_codes;
      logic      settled, buf_like;
      int        i;
      nxt = prev;
      prev_codes = mode_codes(prev);
      r.clear_fail = 1'b0;
      case (it.command)
         pms_pkg::CMD_OBSERVE: begin
            settled = 1'b0;
            for (i = 0; i < MAX_STEPS && !settled; i++) begin
               stepped = apply_rules(nxt, it, prefill);
               if (stepped == nxt) settled = 1'b1;
               else nxt = stepped;
            end
            r.clear_fail = prev == pms_pkg::MODE_SEEKING && nxt != pms_pkg::MODE_SEEKING &&
                           (it.seek_serial & SER_MASK) == 0;
         end
         pms_pkg::CMD_OPEN:
            if (prev == pms_pkg::MODE_IDLE) nxt = pms_pkg::MODE_OPENING;
         pms_pkg::CMD_SEEK:
            if (prev_codes.session == pms_pkg::SES_STARTED) nxt = pms_pkg::MODE_SEEKING;
         pms_pkg::CMD_FINISH_PRIMING:
            if (prev == pms_pkg::MODE_PRIMING) nxt = pms_pkg::MODE_PLAYING;
         pms_pkg::CMD_CLOSE:
            if (prev != pms_pkg::MODE_IDLE) nxt = pms_pkg::MODE_CLOSING;
         pms_pkg::CMD_FINISH_CLOSE:
            if (prev == pms_pkg::MODE_CLOSING) nxt = pms_pkg::MODE_IDLE;
         pms_pkg::CMD_FORCE:
            if (it.target < pms_pkg::NUM_MODES) nxt = pms_pkg::mode_type'(it.target);
         default:
            nxt = pms_pkg::MODE_IDLE;
      endcase
      c = mode_codes(nxt);
      buf_like = c.session == pms_pkg::SES_OPENING || c.buffering == pms_pkg::BUF_PREFILL ||
                 c.buffering == pms_pkg::BUF_PRIMING || c.transport == pms_pkg::TR_SEEKING;
      r.prev_mode     = prev;
      r.mode          = nxt;
      r.changed       = prev != nxt;
      r.session       = c.session;
      r.transport     = c.transport;
      r.buffering     = c.buffering;
      r.hold_audio    = buf_like;
      r.pause_clock   = c.session != pms_pkg::SES_STARTED ||
                        c.buffering == pms_pkg::BUF_PREFILL ||
                        c.transport == pms_pkg::TR_PAUSED;
      r.present_video = c.transport == pms_pkg::TR_SEEKING ||
                        (c.transport == pms_pkg::TR_PLAYING &&
                         c.buffering != pms_pkg::BUF_EMPTY &&
                         c.buffering != pms_pkg::BUF_PREFILL);
      r.ui_busy       = buf_like;
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic request_type blank_request(pms_pkg::cmd_type c, logic [3:0] t,
                                                 logic [10:0] f);
      request_type it;
      it = '0;
      it.command = c;
      it.target  = t;
      it.flags   = f;
      return it;
   endfunction

   // Biased toward the commands and snapshots that move the current mode onward.
   function automatic request_type make_request(pms_pkg::mode_type s, logic [15:0] prefill);
      request_type it;
      int unsigned need;
      int          d;
      it.command      = pms_pkg::CMD_OBSERVE;
      it.target       = 4'($urandom_range(0, 10));
      it.flags        = 11'($urandom_range(0, 2047));
      it.seek_serial  = ($urandom_range(0, 2) == 0) ? $urandom : 32'd0;
      it.cur_serial   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 5);
      it.pend_serial  = ($urandom_range(0, 1) == 0) ? it.cur_serial : $urandom_range(0, 5);
      it.shown_serial = ($urandom_range(0, 1) == 0) ? it.cur_serial : $urandom;
      case ($urandom_range(0, 5))
         0: it.rate = 20'd0;
         1: it.rate = 20'd44100;
         2: it.rate = 20'd48000;
         3: it.rate = 20'd8000;
         4: it.rate = 20'($urandom_range(0, 20'hFFFFF));
         default: it.rate = 20'hFFFFF;
      endcase
      need = ((it.rate == 0) ? pms_pkg::DEFAULT_RATE : int'(it.rate)) / 3;
      case ($urandom_range(0, 4))
         0: it.buffered = (need > 0) ? 24'(need - 1) : 24'd0;
         1: it.buffered = 24'(need);
         2: it.buffered = 24'(need + $urandom_range(0, 100));
         3: it.buffered = 24'($urandom_range(0, 24'hFFFFFF));
         default: it.buffered = 24'($urandom_range(0, need));
      endcase
      if ($urandom_range(0, 3) == 0) begin
         it.depth = 16'($urandom_range(0, 65535));
      end else begin
         d = int'(prefill) + int'($urandom_range(0, 2)) - 1;
         if (d < 0) d = 0;
         if (d > 65535) d = 65535;
         it.depth = 16'(d);
      end

      if ($urandom_range(0, 99) < 12) begin
         // noise: anything at all
         it.command = pms_pkg::cmd_type'($urandom_range(0, 7));
         it.target  = 4'($urandom_range(0, 15));
         it.seek_serial = $urandom;
         return it;
      end

      case (s)
         pms_pkg::MODE_IDLE:
            if ($urandom_range(0, 99) < 85) it.command = pms_pkg::CMD_OPEN;
         pms_pkg::MODE_OPENING: begin
            it.flags[pms_pkg::F_INIT_DONE] = $urandom_range(0, 9) < 8;
            it.flags[pms_pkg::F_INIT_OK]   = $urandom_range(0, 19) < 17;
         end
         pms_pkg::MODE_PREFILL:
            it.flags[pms_pkg::F_AUDIO_PAUSED] = $urandom_range(0, 9) < 2;
         pms_pkg::MODE_PRIMING:
            if ($urandom_range(0, 9) < 7) it.command = pms_pkg::CMD_FINISH_PRIMING;
         pms_pkg::MODE_PLAYING, pms_pkg::MODE_PAUSED, pms_pkg::MODE_DRAINING: begin
            case ($urandom_range(0, 19))
               0, 1, 2: it.command = pms_pkg::CMD_SEEK;
               3:       it.command = pms_pkg::CMD_CLOSE;
               default: ;
            endcase
            it.flags[pms_pkg::F_AUDIO_PAUSED] = $urandom_range(0, 9) < 3;
            if ($urandom_range(0, 9) < 7) it.flags[pms_pkg::F_DECODE_ENDED] = 1'b0;
         end
         pms_pkg::MODE_SEEKING:
            if ($urandom_range(0, 9) < 7) it.seek_serial = 32'd0;
         pms_pkg::MODE_ENDED, pms_pkg::MODE_ERROR:
            case ($urandom_range(0, 9))
               0:       it.command = pms_pkg::CMD_RESET_IDLE;
               1, 2:    ;
               default: it.command = pms_pkg::CMD_CLOSE;
            endcase
         pms_pkg::MODE_CLOSING:
            if ($urandom_range(0, 9) < 8) it.command = pms_pkg::CMD_FINISH_CLOSE;
         default: ;
      endcase
      return it;
   endfunction

   task automatic queue_request(request_type it);
      response_type r;
      r = predict_response(gen_mode, it, prefill_cfg);
      gen_mode = r.mode;
      request_queue.push_back(it);
      queued_count++;
   endtask

   task automatic wait_until_drained();
      do @(posedge clock);
      while (accepted_count != queued_count || predicted_results.size() != 0);
   endtask

   task automatic write_prefill(logic [15:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      prefill_cfg = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // ---------------------------------------------------------------- driver

   request_type  drive_req;
   response_type drive_rsp;
   logic      offering = 1'b0;
   int        gap_left = 0;
   int        burst_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         offering = 1'b0;
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            drive_rsp = predict_response(model_mode, drive_req, prefill_cfg);
            model_mode = drive_rsp.mode;
            modes_seen[drive_rsp.mode] = 1'b1;
            predicted_results.push_back(drive_rsp);
            accepted_count++;
            offering = 1'b0;
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (request_queue.size() > 0) begin
               drive_req = request_queue.pop_front();
               offering = 1'b1;
               req_command               <= drive_req.command;
               req_target_state          <= drive_req.target;
               req_status_flags          <= drive_req.flags;
               req_seek_in_flight_serial <= drive_req.seek_serial;
               req_pending_seek_serial   <= drive_req.pend_serial;
               req_current_serial        <= drive_req.cur_serial;
               req_last_presented_serial <= drive_req.shown_serial;
               req_video_queue_depth     <= drive_req.depth;
               req_audio_buffered_frames <= drive_req.buffered;
               req_audio_sample_rate     <= drive_req.rate;
               if (burst_left == 0) burst_left = $urandom_range(1, 30);
               burst_left--;
               if (burst_left == 0)
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
         req_valid <= offering;
      end
   end

   // ---------------------------------------------------------------- monitor

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   response_type seen;
   int        stall_tick = 0;
   int        stall_mode = 0;
   int        hold_left = 0;
   int        holds_done = 0;
   logic      ready_next;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            checked_count++;
            if (predicted_results.size() == 0) begin
               $error("result with no transaction outstanding");
               errors++;
            end else begin
               seen = predicted_results.pop_front();
               check_field("previous_state", seen.prev_mode, rsp_previous_state);
               check_field("current_state", seen.mode, rsp_current_state);
               check_field("state_changed", seen.changed, rsp_state_changed);
               check_field("clear_seek_failure", seen.clear_fail, rsp_clear_seek_failure);
               check_field("session_code", seen.session, rsp_session_code);
               check_field("transport_code", seen.transport, rsp_transport_code);
               check_field("buffering_code", seen.buffering, rsp_buffering_code);
               check_field("hold_audio_output", seen.hold_audio, rsp_hold_audio_output);
               check_field("pause_main_clock", seen.pause_clock, rsp_pause_main_clock);
               check_field("may_present_video", seen.present_video, rsp_may_present_video);
               check_field("ui_buffering", seen.ui_busy, rsp_ui_buffering);
            end
         end
         stall_tick++;
         if (stall_tick % 50 == 0) stall_mode = $urandom_range(0, 3);
         if (holds_done < hold_requests && hold_left == 0) begin
            hold_left = LONG_HOLD;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            case (stall_mode)
               0:       ready_next = 1'b1;
               1:       ready_next = $urandom_range(0, 1);
               2:       ready_next = (stall_tick % 4) == 0;
               default: ready_next = $urandom_range(0, 4) != 0;
            endcase
         end
         rsp_ready <= ready_next;
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------- sequence

   logic [15:0] cfg_list [PHASES];
   request_type it;
   int          p, n;

   initial begin
      cfg_list = '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd16, 16'd8};
      cfg_list[3] = 16'($urandom_range(0, 65535));
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed, register at its reset value
      queue_request(blank_request(pms_pkg::CMD_OBSERVE, 4'd0, '0));
      it = '1;
      queue_request(it);                                    // every field at its top value
      queue_request(blank_request(pms_pkg::CMD_FORCE, 4'd15, '0)); // unknown target ignored
      queue_request(blank_request(pms_pkg::CMD_CLOSE, 4'd0, '0));
      queue_request(blank_request(pms_pkg::CMD_SEEK, 4'd0, '0));
      queue_request(blank_request(pms_pkg::CMD_FINISH_PRIMING, 4'd0, '0));
      queue_request(blank_request(pms_pkg::CMD_FINISH_CLOSE, 4'd0, '0));
      queue_request(blank_request(pms_pkg::CMD_OPEN, 4'd0, '0));
      queue_request(blank_request(pms_pkg::CMD_OPEN, 4'd0, '0));
      queue_request(blank_request(pms_pkg::CMD_OBSERVE, 4'd0, FL_INIT_DONE)); // init failed
      queue_request(blank_request(pms_pkg::CMD_CLOSE, 4'd0, '0));
      queue_request(blank_request(pms_pkg::CMD_FINISH_CLOSE, 4'd0, '0));
      queue_request(blank_request(pms_pkg::CMD_OPEN, 4'd0, '0));
      queue_request(blank_request(pms_pkg::CMD_OBSERVE, 4'd0,
                                  FL_INIT_DONE | FL_INIT_OK | FL_PAUSED));
      it = blank_request(pms_pkg::CMD_OBSERVE, 4'd0, '0);
      it.shown_serial = 32'd1;
      it.cur_serial   = 32'd2;
      queue_request(it);                                    // resume onto a new stream
      it = blank_request(pms_pkg::CMD_OBSERVE, 4'd0, FL_AUDIO_STARTED | FL_SYNC_READY);
      it.depth    = 16'd8;
      it.buffered = 24'd16000;                              // unknown rate, exact threshold
      queue_request(it);
      queue_request(blank_request(pms_pkg::CMD_FINISH_PRIMING, 4'd0, '0));
      queue_request(blank_request(pms_pkg::CMD_OBSERVE, 4'd0, FL_PAUSED));
      it = blank_request(pms_pkg::CMD_OBSERVE, 4'd0, '0);
      it.shown_serial = 32'd5;
      it.cur_serial   = 32'd5;
      queue_request(it);
      queue_request(blank_request(pms_pkg::CMD_OBSERVE, 4'd0, FL_DEMUX_ENDED | FL_VQ_EMPTY));
      queue_request(blank_request(pms_pkg::CMD_OBSERVE, 4'd0,
                                  FL_DECODE_ENDED | FL_VQ_EMPTY | FL_AUDIO_STARTED |
                                  FL_AUDIO_FIN));
      queue_request(blank_request(pms_pkg::CMD_FORCE, 4'd4, '0));
      queue_request(blank_request(pms_pkg::CMD_SEEK, 4'd0, '0));
      it = blank_request(pms_pkg::CMD_OBSERVE, 4'd0, '0);
      it.seek_serial = 32'd7;
      queue_request(it);                                    // seek still in flight
      it = blank_request(pms_pkg::CMD_OBSERVE, 4'd0, FL_PAUSED);
      it.pend_serial = 32'd3;
      it.cur_serial  = 32'd3;
      queue_request(it);                                    // paused seek holds
      it = blank_request(pms_pkg::CMD_OBSERVE, 4'd0,
                         FL_SEEK_FAILED | FL_DECODE_ENDED | FL_VQ_EMPTY);
      it.rate = 20'hFFFFF;
      queue_request(it);                                    // seeking through to ended
      queue_request(blank_request(pms_pkg::CMD_FORCE, 4'd10, '0));
      queue_request(blank_request(pms_pkg::CMD_RESET_IDLE, 4'd0, '0));

      for (p = 0; p < PHASES; p++) begin
         wait_until_drained();
         write_prefill(cfg_list[p]);
         if (p == 1) hold_requests++;
         for (n = 0; n < PHASE_ITEMS; n++) queue_request(make_request(gen_mode, prefill_cfg));
      end
      wait_until_drained();
      repeat (MAX_STEPS + 4) @(posedge clock);

      if (predicted_results.size() != 0) begin
         $error("%0d results never arrived", predicted_results.size());
         errors++;
      end
      $display("%0d transactions checked across %0d prefill settings, %0d of %0d modes reached",
               checked_count, PHASES + 1, $countones(modes_seen), pms_pkg::NUM_MODES);
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
